// ----- hw/rtl/ttam_pkg.sv -----
// Shared types and constants for the tensor transpose address map.
// No dependencies; imported by every module of the block.
package ttam_pkg;

  localparam int MAX_RANK    = 4;
  localparam int INDEX_WIDTH = 24;
  localparam int DIM_WIDTH   = 13;
  localparam int RANK_WIDTH  = 3;
  localparam int PERM_WIDTH  = 8;
  localparam int AXIS_WIDTH  = 2;
  localparam int CFG_WIDTH   = 13;
  localparam int CFG_IDX_W   = 3;
  localparam int MAC_STAGES  = 2;
  // one register per cell, MAC stages per axis, plus the result register
  localparam int PIPE_LATENCY = MAX_RANK * (INDEX_WIDTH + MAC_STAGES) + 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RANK      = 3'd0,
    REG_DIM_ZERO  = 3'd1,
    REG_DIM_ONE   = 3'd2,
    REG_DIM_TWO   = 3'd3,
    REG_DIM_THREE = 3'd4,
    REG_PERM      = 3'd5
  } ttam_reg_t;

  // data travelling down the cell chain
  typedef struct packed {
    logic                   valid;
    logic [INDEX_WIDTH-1:0] dq;   // remaining dividend bits / quotient bits
    logic [DIM_WIDTH-1:0]   rem;
    logic [INDEX_WIDTH-1:0] acc;
  } ttam_lane_t;

  // per-slot constants derived from configuration
  typedef struct packed {
    logic [DIM_WIDTH-1:0]   divisor;
    logic [INDEX_WIDTH-1:0] stride;
  } ttam_axis_t;

endpackage

// ----- hw/rtl/ttam_div_cell.sv -----
// One restoring-division step: one quotient bit per cell.
// Depends on ttam_pkg.
module ttam_div_cell (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [ttam_pkg::DIM_WIDTH-1:0] divisor,
  input  ttam_pkg::ttam_lane_t          lane_in,
  output ttam_pkg::ttam_lane_t          lane_out
);
  import ttam_pkg::*;

  logic [DIM_WIDTH:0] shifted;
  logic [DIM_WIDTH:0] diff;
  logic               ge;
  ttam_lane_t         lane_next;

  always_comb begin
    shifted = {lane_in.rem, lane_in.dq[INDEX_WIDTH-1]};
    diff    = shifted - {1'b0, divisor};
    ge      = (shifted >= {1'b0, divisor});
    lane_next       = lane_in;
    lane_next.valid = lane_in.valid & ~rst;
    lane_next.rem   = ge ? diff[DIM_WIDTH-1:0] : shifted[DIM_WIDTH-1:0];
    lane_next.dq    = {lane_in.dq[INDEX_WIDTH-2:0], ge};
  end

  always_ff @(posedge clk) begin
    lane_out <= lane_next;
  end

endmodule

// ----- hw/rtl/ttam_mac_cell.sv -----
// Coordinate times source stride, added to the running address (two stages).
// Depends on ttam_pkg.
module ttam_mac_cell (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [ttam_pkg::INDEX_WIDTH-1:0] stride,
  input  ttam_pkg::ttam_lane_t            lane_in,
  output ttam_pkg::ttam_lane_t            lane_out
);
  import ttam_pkg::*;

  localparam int PROD_W = INDEX_WIDTH + DIM_WIDTH;

  ttam_lane_t             mid;
  ttam_lane_t             mid_next;
  logic [PROD_W-1:0]      prod_full;
  ttam_lane_t             lane_next;

  always_comb begin
    prod_full = {{INDEX_WIDTH{1'b0}}, lane_in.rem} * {{DIM_WIDTH{1'b0}}, stride};
    mid_next       = lane_in;
    mid_next.valid = lane_in.valid & ~rst;
  end

  // stage 1: product held in the rem/acc slots is avoided; keep it separate
  logic [INDEX_WIDTH-1:0] prod;

  always_ff @(posedge clk) begin
    mid  <= mid_next;
    prod <= prod_full[INDEX_WIDTH-1:0];
  end

  always_comb begin
    lane_next       = mid;
    lane_next.valid = mid.valid & ~rst;
    lane_next.acc   = mid.acc + prod;
    lane_next.rem   = '0;
  end

  always_ff @(posedge clk) begin
    lane_out <= lane_next;
  end

endmodule

// ----- hw/rtl/ttam_stride.sv -----
// Derives per-slot divisors, source strides and the permutation error flag.
// Depends on ttam_pkg.
module ttam_stride (
  input  logic                              clk,
  input  logic [ttam_pkg::RANK_WIDTH-1:0]    tensor_rank,
  input  logic [ttam_pkg::DIM_WIDTH-1:0]     dims [ttam_pkg::MAX_RANK],
  input  logic [ttam_pkg::PERM_WIDTH-1:0]    perm_map,
  output ttam_pkg::ttam_axis_t              axis_cfg [ttam_pkg::MAX_RANK],
  output logic                              perm_err
);
  import ttam_pkg::*;

  localparam int PROD_W = INDEX_WIDTH + DIM_WIDTH;

  logic [RANK_WIDTH-1:0]  rank;
  logic [DIM_WIDTH-1:0]   dim_fix [MAX_RANK];
  logic [DIM_WIDTH-1:0]   eff     [MAX_RANK];
  logic [AXIS_WIDTH-1:0]  perm    [MAX_RANK];
  logic [INDEX_WIDTH-1:0] sstride [MAX_RANK];
  logic [PROD_W-1:0]      prod    [MAX_RANK-1];

  always_comb begin
    rank = tensor_rank;
    if (rank == '0) begin
      rank = RANK_WIDTH'(1);
    end else if (rank > RANK_WIDTH'(MAX_RANK)) begin
      rank = RANK_WIDTH'(MAX_RANK);
    end
    for (int j = 0; j < MAX_RANK; j++) begin
      dim_fix[j] = (dims[j] == '0) ? DIM_WIDTH'(1) : dims[j];
      eff[j]     = (RANK_WIDTH'(j) < rank) ? dim_fix[j] : DIM_WIDTH'(1);
      perm[j]    = perm_map[2*j +: AXIS_WIDTH];
    end
  end

  // strides built innermost first, one registered multiply per step
  assign sstride[MAX_RANK-1] = INDEX_WIDTH'(1);
  genvar k;
  generate
    for (k = 0; k < MAX_RANK - 1; k++) begin : g_str
      logic [INDEX_WIDTH-1:0] str_q;
      assign prod[k] = {{DIM_WIDTH{1'b0}}, sstride[k+1]} *
                       {{INDEX_WIDTH{1'b0}}, eff[k+1]};
      always_ff @(posedge clk) begin
        str_q <= prod[k][INDEX_WIDTH-1:0];
      end
      assign sstride[k] = str_q;
    end
  endgenerate

  always_comb begin
    logic [RANK_WIDTH-1:0] d;
    perm_err = 1'b0;
    for (int j = 0; j < MAX_RANK; j++) begin
      if ((RANK_WIDTH'(j) < rank) && ({1'b0, perm[j]} >= rank)) begin
        perm_err = 1'b1;
      end
    end
    // slot p handles output axis rank-1-p, innermost first
    for (int p = 0; p < MAX_RANK; p++) begin
      d = rank - RANK_WIDTH'(1) - RANK_WIDTH'(p);
      if (RANK_WIDTH'(p) < rank) begin
        axis_cfg[p].divisor = dim_fix[perm[d[AXIS_WIDTH-1:0]]];
        axis_cfg[p].stride  = sstride[perm[d[AXIS_WIDTH-1:0]]];
      end else begin
        axis_cfg[p].divisor = DIM_WIDTH'(1);
        axis_cfg[p].stride  = '0;
      end
    end
  end

endmodule

// ----- hw/rtl/tensor_transpose_address_map.sv -----
// Transposed-tensor address map: output linear index in, source linear index out.
// One transaction accepted every cycle while not in reset.
// Synchronous active-high reset clears the pipeline valids and loads register defaults.
// No back-pressure: done strobes for one cycle and the receiver cannot stall it.
module tensor_transpose_address_map (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [ttam_pkg::INDEX_WIDTH-1:0]   out_index,
  output logic                              done,
  output logic [ttam_pkg::INDEX_WIDTH-1:0]   src_index,
  output logic                              perm_error,
  input  logic                              cfg_write,
  input  logic [ttam_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ttam_pkg::CFG_WIDTH-1:0]     cfg_data
);
  import ttam_pkg::*;

  // Each output axis is split off by repeated division, innermost first:
  // 24 division cells leave coord in rem and the next index in dq, then a
  // MAC cell adds coord * source stride. Four axis slots, unused ones divide
  // by one and add nothing. The user must change config only when idle;
  // the block has no check for it. The strides lag a write, being registered.

  logic [RANK_WIDTH-1:0] tensor_rank;
  logic [DIM_WIDTH-1:0]  dims [MAX_RANK];
  logic [PERM_WIDTH-1:0] perm_map;

  always_ff @(posedge clk) begin
    if (rst) begin
      tensor_rank <= RANK_WIDTH'(4);
      for (int j = 0; j < MAX_RANK; j++) begin
        dims[j] <= DIM_WIDTH'(1);
      end
      perm_map <= PERM_WIDTH'(228);
    end else if (cfg_write) begin
      unique case (ttam_reg_t'(cfg_index))
        REG_RANK:      tensor_rank <= cfg_data[RANK_WIDTH-1:0];
        REG_DIM_ZERO:  dims[0]     <= cfg_data[DIM_WIDTH-1:0];
        REG_DIM_ONE:   dims[1]     <= cfg_data[DIM_WIDTH-1:0];
        REG_DIM_TWO:   dims[2]     <= cfg_data[DIM_WIDTH-1:0];
        REG_DIM_THREE: dims[3]     <= cfg_data[DIM_WIDTH-1:0];
        REG_PERM:      perm_map    <= cfg_data[PERM_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  ttam_axis_t axis_cfg [MAX_RANK];
  logic       perm_err;

  ttam_stride u_stride (
    .clk         (clk),
    .tensor_rank (tensor_rank),
    .dims        (dims),
    .perm_map    (perm_map),
    .axis_cfg    (axis_cfg),
    .perm_err    (perm_err)
  );

  // never stalls; only held off while in reset
  assign busy = rst;

  ttam_lane_t axis_lane [MAX_RANK+1];

  assign axis_lane[0] = '{valid: start & ~busy, dq: out_index, rem: '0, acc: '0};

  genvar p, b;
  generate
    for (p = 0; p < MAX_RANK; p++) begin : g_axis
      ttam_lane_t chain [INDEX_WIDTH+1];
      assign chain[0] = axis_lane[p];
      for (b = 0; b < INDEX_WIDTH; b++) begin : g_bit
        ttam_div_cell u_div (
          .clk      (clk),
          .rst      (rst),
          .divisor  (axis_cfg[p].divisor),
          .lane_in  (chain[b]),
          .lane_out (chain[b+1])
        );
      end
      ttam_mac_cell u_mac (
        .clk      (clk),
        .rst      (rst),
        .stride   (axis_cfg[p].stride),
        .lane_in  (chain[INDEX_WIDTH]),
        .lane_out (axis_lane[p+1])
      );
    end
  endgenerate

  // result register; a bad permutation forces the address to zero
  always_ff @(posedge clk) begin
    src_index  <= perm_err ? '0 : axis_lane[MAX_RANK].acc;
    perm_error <= perm_err;
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= axis_lane[MAX_RANK].valid;
    end
  end

endmodule

// ----- hw/rtl/ttam_checker.sv -----
// Port-level checks for the transpose address map, bound to the top level.
// Depends on ttam_pkg.
module ttam_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              start,
  input logic                              busy,
  input logic                              done,
  input logic [ttam_pkg::INDEX_WIDTH-1:0]   src_index,
  input logic                              perm_error
);
  import ttam_pkg::*;

  a_done_follows: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##PIPE_LATENCY done)
    else $error("accepted transaction gave no done");

  a_done_cause: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, PIPE_LATENCY))
    else $error("done does not follow an accepted transaction");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (done && perm_error) |-> (src_index == '0))
    else $error("address not zero on permutation error");

  a_reset_quiet: assert property (@(posedge clk)
    $past(rst) |-> !done)
    else $error("done raised straight after reset");

endmodule

bind tensor_transpose_address_map ttam_checker u_ttam_checker (.*);
